// ===== rtl/core/gzla_pkg.sv =====
// Shared types and constants of the grid zone luma average block.
`default_nettype none

package gzla_pkg;

  localparam int unsigned DIM_W     = 12;
  localparam int unsigned SUM_W     = 24;
  localparam int unsigned DIV_STEPS = 24;
  localparam int unsigned CNT_W     = 5;

  localparam logic [DIM_W-1:0] DIM_LIMIT = 12'd2048;
  localparam logic [DIM_W-1:0] FW_RESET  = 12'd320;
  localparam logic [DIM_W-1:0] FH_RESET  = 12'd240;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] luma;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [7:0] average;
    logic       last_cell;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_HOLD
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic s1_emit;
    logic out_free;
  } sts_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_LIMIT) ? DIM_LIMIT : v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/grid_zone_luma_average.sv =====
// Top level of the grid zone luma average block.
//
// Input channel (in_valid, in_stall, in_data): one luma sample per item in
// raster order; frame_start marks the first pixel of a frame. The frame is cut
// into GRID_COLUMNS by GRID_ROWS cells sized from the frame_width and
// frame_height registers, set over the APB-style port (offsets 0 and 4).
// Output channel (out_valid, out_stall, out_data): one item per finished cell
// with its grid column, grid row, truncated mean luma and a last-cell flag.
// Throughput: while no cell result is pending, an item that finishes no cell
// is taken every cycle. An item that finishes a cell sends its sum through a
// 24-step restoring divider; input stalls while the sum is loaded, through
// the divider steps and until the result enters the output register.
// A waiting result sits in the output register; input is taken while it waits
// until the next cell finishes, which then holds until out_stall drops.
// Reset: registers return to 320 by 240, counters and accumulators clear at
// once through per-column valid bits; items are accepted in the first cycle.
`default_nettype none

module grid_zone_luma_average
  import gzla_pkg::*;
#(
  parameter int unsigned GRID_COLUMNS = 16,
  parameter int unsigned GRID_ROWS    = 9
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  gzla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  gzla_dpath #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting item");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  a_div_src: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_load |-> sts.s1_emit)
    else $error("divider started without a finished cell");

  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !sts.s1_emit)
    else $error("item taken while a cell result is pending");

endmodule

`default_nettype wire

// ===== rtl/core/gzla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gzla_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/gzla_ctrl.sv =====
// Controller state machine: input flow, divider sequencing and result hand-off.
`default_nettype none

module gzla_ctrl
  import gzla_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire sts_t sts,
  output logic      in_stall,
  output cmd_t      cmd
);

  ctl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    case (state_r)
      ST_RUN: begin
        if (sts.s1_emit) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_HOLD;
          cnt_nxt   = '0;
        end
      end
      ST_HOLD: begin
        if (sts.out_free) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd          = '0;
    case (state_r)
      ST_RUN: begin
        in_stall     = sts.s1_emit;
        cmd.div_load = sts.s1_emit;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_HOLD: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    cmd.accept = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gzla_dpath.sv =====
// Datapath: registers, position counters, column accumulators, divider, output register.
`default_nettype none

module gzla_dpath
  import gzla_pkg::*;
#(
  parameter int unsigned GRID_COLUMNS = 16,
  parameter int unsigned GRID_ROWS    = 9
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  input  wire in_item_t    in_data,
  input  wire logic        out_stall,
  output logic             out_valid,
  output out_item_t        out_data,
  input  wire cmd_t        cmd,
  output sts_t             sts
);

  localparam int unsigned AW  = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int unsigned GCW = $clog2(GRID_COLUMNS + 1);
  localparam int unsigned GRW = $clog2(GRID_ROWS + 1);
  localparam int unsigned SW  = DIM_W + $clog2(GRID_COLUMNS);
  localparam int unsigned SH  = DIM_W + $clog2(GRID_ROWS);
  localparam int unsigned MW  = ((2 ** SW) + GRID_COLUMNS - 1) / GRID_COLUMNS;
  localparam int unsigned MH  = ((2 ** SH) + GRID_ROWS - 1) / GRID_ROWS;
  localparam int unsigned PW  = SW + DIM_W + 1;
  localparam int unsigned PH  = SH + DIM_W + 1;
  localparam logic [DIM_W-1:0] CW_RST = DIM_W'(FW_RESET / GRID_COLUMNS);
  localparam logic [DIM_W-1:0] CH_RST = DIM_W'(FH_RESET / GRID_ROWS);

  // configuration and derived cell sizes
  logic [DIM_W-1:0] fw_r, fw_nxt, fh_r, fh_nxt;
  logic [DIM_W-1:0] cw_r, cw_nxt, ch_r, ch_nxt;
  logic [DIM_W-1:0] eff_in, eff_w, eff_h;
  logic [PW-1:0]    prod_w;
  logic [PH-1:0]    prod_h;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign eff_in = eff_dim(pwdata[DIM_W-1:0]);
  assign prod_w = PW'(eff_in) * PW'(MW);
  assign prod_h = PH'(eff_in) * PH'(MH);
  assign eff_w  = eff_dim(fw_r);
  assign eff_h  = eff_dim(fh_r);

  always_comb begin
    fw_nxt = fw_r;
    fh_nxt = fh_r;
    cw_nxt = cw_r;
    ch_nxt = ch_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH: begin
          fw_nxt = pwdata[DIM_W-1:0];
          cw_nxt = prod_w[SW+DIM_W-1:SW];
        end
        REG_FRAME_HEIGHT: begin
          fh_nxt = pwdata[DIM_W-1:0];
          ch_nxt = prod_h[SH+DIM_W-1:SH];
        end
        default: begin
          fw_nxt = fw_r;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = 32'(fw_r);
      REG_FRAME_HEIGHT: prdata = 32'(fh_r);
      default:          prdata = '0;
    endcase
  end

  // position counters
  logic [10:0]    pc_r, pc_nxt, pr_r, pr_nxt, pc_c, pr_c;
  logic [7:0]     cic_r, cic_nxt, ric_r, ric_nxt, cic_c, ric_c;
  logic [GCW-1:0] gc_r, gc_nxt, gc_c;
  logic [GRW-1:0] gr_r, gr_nxt, gr_c;
  logic [8:0]     cic_inc, ric_inc;
  logic [11:0]    pc_inc, pr_inc;
  logic           start, sizes_ok, in_cols, in_rows, cw_hit, ch_hit;
  logic           acc, emit, last, line_end, frame_end;
  logic [AW-1:0]  x_addr;
  logic [31:0]    gc_ext, gr_ext;

  assign start     = in_data.frame_start;
  assign pc_c      = start ? '0 : pc_r;
  assign pr_c      = start ? '0 : pr_r;
  assign cic_c     = start ? '0 : cic_r;
  assign ric_c     = start ? '0 : ric_r;
  assign gc_c      = start ? '0 : gc_r;
  assign gr_c      = start ? '0 : gr_r;
  assign sizes_ok  = (cw_r != '0) && (ch_r != '0);
  assign in_cols   = gc_c < GCW'(GRID_COLUMNS);
  assign in_rows   = gr_c < GRW'(GRID_ROWS);
  assign cic_inc   = {1'b0, cic_c} + 9'd1;
  assign ric_inc   = {1'b0, ric_c} + 9'd1;
  assign cw_hit    = DIM_W'(cic_inc) >= cw_r;
  assign ch_hit    = DIM_W'(ric_inc) >= ch_r;
  assign acc       = sizes_ok && in_cols && in_rows;
  assign emit      = acc && cw_hit && ch_hit;
  assign last      = (gc_c == GCW'(GRID_COLUMNS - 1)) && (gr_c == GRW'(GRID_ROWS - 1));
  assign pc_inc    = {1'b0, pc_c} + 12'd1;
  assign pr_inc    = {1'b0, pr_c} + 12'd1;
  assign line_end  = pc_inc >= eff_w;
  assign frame_end = line_end && (pr_inc >= eff_h);
  assign x_addr    = gc_c[AW-1:0];
  assign gc_ext    = 32'(gc_c);
  assign gr_ext    = 32'(gr_c);

  always_comb begin
    pc_nxt  = pc_r;
    pr_nxt  = pr_r;
    cic_nxt = cic_r;
    ric_nxt = ric_r;
    gc_nxt  = gc_r;
    gr_nxt  = gr_r;
    if (cmd.accept) begin
      cic_nxt = cic_c;
      ric_nxt = ric_c;
      gc_nxt  = gc_c;
      gr_nxt  = gr_c;
      pr_nxt  = pr_c;
      if (sizes_ok && in_cols) begin
        if (cw_hit) begin
          cic_nxt = '0;
          gc_nxt  = gc_c + GCW'(1);
        end else begin
          cic_nxt = cic_inc[7:0];
        end
      end
      if (line_end) begin
        pc_nxt  = '0;
        cic_nxt = '0;
        gc_nxt  = '0;
        if (sizes_ok && in_rows) begin
          if (ch_hit) begin
            ric_nxt = '0;
            gr_nxt  = gr_c + GRW'(1);
          end else begin
            ric_nxt = ric_inc[7:0];
          end
        end
        if (frame_end) begin
          pr_nxt  = '0;
          ric_nxt = '0;
          gr_nxt  = '0;
        end else begin
          pr_nxt = pr_inc[10:0];
        end
      end else begin
        pc_nxt = pc_inc[10:0];
      end
    end
  end

  // accumulate stage
  logic              s1_v_r, s1_v_nxt;
  logic [7:0]        s1_luma_r;
  logic [AW-1:0]     s1_addr_r;
  logic              s1_acc_r, s1_emit_r, s1_wrap_r, s1_fwd_r, s1_last_r;
  logic [3:0]        s1_x_r, s1_y_r;
  logic              s1_fwd_nxt;
  logic [SUM_W-1:0]  fwd_val_r, ram_rdata, base, sum, wdata;
  logic [GRID_COLUMNS-1:0] vld_r, vld_nxt;

  assign s1_v_nxt   = cmd.accept;
  assign s1_fwd_nxt = s1_v_r && s1_acc_r && !s1_wrap_r && !start && (s1_addr_r == x_addr);
  assign base       = s1_fwd_r ? fwd_val_r : (vld_r[s1_addr_r] ? ram_rdata : '0);
  assign sum        = base + SUM_W'(s1_luma_r);
  assign wdata      = s1_emit_r ? '0 : sum;

  always_comb begin
    vld_nxt = vld_r;
    if (s1_v_r && s1_acc_r) begin
      vld_nxt[s1_addr_r] = 1'b1;
    end
    if ((s1_v_r && s1_wrap_r) || (cmd.accept && start)) begin
      vld_nxt = '0;
    end
  end

  gzla_ram #(
    .WIDTH (SUM_W),
    .DEPTH (GRID_COLUMNS)
  ) u_sums (
    .clk   (clk),
    .we    (s1_v_r && s1_acc_r),
    .waddr (s1_addr_r),
    .wdata (wdata),
    .raddr (x_addr),
    .rdata (ram_rdata)
  );

  // restoring divider, one quotient bit per step
  logic [SUM_W-1:0] div_rem_r, div_rem_nxt, div_q_r, div_q_nxt, div_dvs_r, div_dvs_nxt;
  logic [3:0]       div_x_r, div_x_nxt, div_y_r, div_y_nxt;
  logic             div_last_r, div_last_nxt;
  logic [SUM_W:0]   div_trial, div_diff;
  logic [SUM_W-1:0] area;

  assign area      = SUM_W'(cw_r) * SUM_W'(ch_r);
  assign div_trial = {div_rem_r, div_q_r[SUM_W-1]};
  assign div_diff  = div_trial - {1'b0, div_dvs_r};

  always_comb begin
    div_rem_nxt  = div_rem_r;
    div_q_nxt    = div_q_r;
    div_dvs_nxt  = div_dvs_r;
    div_x_nxt    = div_x_r;
    div_y_nxt    = div_y_r;
    div_last_nxt = div_last_r;
    if (cmd.div_load) begin
      div_rem_nxt  = '0;
      div_q_nxt    = sum;
      div_dvs_nxt  = area;
      div_x_nxt    = s1_x_r;
      div_y_nxt    = s1_y_r;
      div_last_nxt = s1_last_r;
    end else if (cmd.div_step) begin
      if (!div_diff[SUM_W]) begin
        div_rem_nxt = div_diff[SUM_W-1:0];
      end else begin
        div_rem_nxt = div_trial[SUM_W-1:0];
      end
      div_q_nxt = {div_q_r[SUM_W-2:0], !div_diff[SUM_W]};
    end
  end

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (cmd.out_load) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.cell_x    = div_x_r;
      out_data_nxt.cell_y    = div_y_r;
      out_data_nxt.average   = div_q_r[7:0];
      out_data_nxt.last_cell = div_last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.s1_emit  = s1_v_r && s1_emit_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r        <= FW_RESET;
      fh_r        <= FH_RESET;
      cw_r        <= CW_RST;
      ch_r        <= CH_RST;
      pc_r        <= '0;
      pr_r        <= '0;
      cic_r       <= '0;
      ric_r       <= '0;
      gc_r        <= '0;
      gr_r        <= '0;
      s1_v_r      <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fw_r        <= fw_nxt;
      fh_r        <= fh_nxt;
      cw_r        <= cw_nxt;
      ch_r        <= ch_nxt;
      pc_r        <= pc_nxt;
      pr_r        <= pr_nxt;
      cic_r       <= cic_nxt;
      ric_r       <= ric_nxt;
      gc_r        <= gc_nxt;
      gr_r        <= gr_nxt;
      s1_v_r      <= s1_v_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s1_luma_r <= in_data.luma;
      s1_addr_r <= x_addr;
      s1_acc_r  <= acc;
      s1_emit_r <= emit;
      s1_wrap_r <= frame_end;
      s1_fwd_r  <= s1_fwd_nxt;
      s1_x_r    <= gc_ext[3:0];
      s1_y_r    <= gr_ext[3:0];
      s1_last_r <= last;
    end
    if (s1_v_r) begin
      fwd_val_r <= wdata;
    end
    div_rem_r  <= div_rem_nxt;
    div_q_r    <= div_q_nxt;
    div_dvs_r  <= div_dvs_nxt;
    div_x_r    <= div_x_nxt;
    div_y_r    <= div_y_nxt;
    div_last_r <= div_last_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for grid_zone_luma_average: directed table and random frames.
module tb_top
  import gzla_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ZONE_COLS    = 16;
  localparam int unsigned ZONE_ROWS    = 9;
  localparam int unsigned SUM_MASK     = 32'h00FF_FFFF;
  localparam int unsigned CELL_LATENCY = 30;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AFTER   = 60;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned PAUSE_PHASE  = 3;
  localparam int unsigned PAUSE_AT     = 100;
  localparam int unsigned N_STEPS      = 24;
  localparam int unsigned N_PHASES     = 9;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_WIDTH, ROW_HEIGHT} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [11:0] value;
    logic        fs;
    logic        typed;
    logic        has_cell;
    out_item_t   exp_res;
  } step_row_t;

  typedef struct packed {
    logic [11:0] w_lo;
    logic [11:0] w_hi;
    logic [11:0] h_lo;
    logic [11:0] h_hi;
    logic [15:0] items;
    logic        fresh;
  } phase_t;

  localparam out_item_t NO_CELL = '0;

  step_row_t directed_steps [N_STEPS] = '{
    '{ROW_PIXEL,  12'h012, 1'b1, 1'b1, 1'b0, NO_CELL},
    '{ROW_WIDTH,  12'd16,  1'b0, 1'b0, 1'b0, NO_CELL},
    '{ROW_HEIGHT, 12'd9,   1'b0, 1'b0, 1'b0, NO_CELL},
    '{ROW_PIXEL,  12'h000, 1'b1, 1'b1, 1'b1, {4'd0, 4'd0, 8'h00, 1'b0}},
    '{ROW_PIXEL,  12'h0FF, 1'b0, 1'b1, 1'b1, {4'd1, 4'd0, 8'hFF, 1'b0}},
    '{ROW_PIXEL,  12'h055, 1'b0, 1'b1, 1'b1, {4'd2, 4'd0, 8'h55, 1'b0}},
    '{ROW_PIXEL,  12'h0AA, 1'b0, 1'b1, 1'b1, {4'd3, 4'd0, 8'hAA, 1'b0}},
    '{ROW_PIXEL,  12'h001, 1'b1, 1'b1, 1'b1, {4'd0, 4'd0, 8'h01, 1'b0}},
    '{ROW_PIXEL,  12'h0FE, 1'b0, 1'b1, 1'b1, {4'd1, 4'd0, 8'hFE, 1'b0}},
    '{ROW_PIXEL,  12'h080, 1'b1, 1'b1, 1'b1, {4'd0, 4'd0, 8'h80, 1'b0}},
    '{ROW_PIXEL,  12'h07F, 1'b0, 1'b1, 1'b1, {4'd1, 4'd0, 8'h7F, 1'b0}},
    '{ROW_WIDTH,  12'd15,  1'b0, 1'b0, 1'b0, NO_CELL},
    '{ROW_PIXEL,  12'h0FF, 1'b1, 1'b1, 1'b0, NO_CELL},
    '{ROW_PIXEL,  12'h000, 1'b0, 1'b1, 1'b0, NO_CELL},
    '{ROW_WIDTH,  12'hFFF, 1'b0, 1'b0, 1'b0, NO_CELL},
    '{ROW_HEIGHT, 12'd8,   1'b0, 1'b0, 1'b0, NO_CELL},
    '{ROW_PIXEL,  12'h0FF, 1'b1, 1'b1, 1'b0, NO_CELL},
    '{ROW_HEIGHT, 12'hFFF, 1'b0, 1'b0, 1'b0, NO_CELL},
    '{ROW_PIXEL,  12'h033, 1'b0, 1'b0, 1'b0, NO_CELL},
    '{ROW_WIDTH,  12'd16,  1'b0, 1'b0, 1'b0, NO_CELL},
    '{ROW_HEIGHT, 12'd9,   1'b0, 1'b0, 1'b0, NO_CELL},
    '{ROW_PIXEL,  12'h0C3, 1'b0, 1'b0, 1'b0, NO_CELL},
    '{ROW_PIXEL,  12'h03C, 1'b0, 1'b0, 1'b0, NO_CELL},
    '{ROW_PIXEL,  12'h0FF, 1'b1, 1'b1, 1'b1, {4'd0, 4'd0, 8'hFF, 1'b0}}
  };

  phase_t frame_phases [N_PHASES] = '{
    '{12'd16,   12'd16,   12'd9,    12'd9,    16'd290, 1'b1},
    '{12'd17,   12'd17,   12'd10,   12'd10,   16'd175, 1'b1},
    '{12'd2048, 12'd2048, 12'd2048, 12'd2048, 16'd25,  1'b0},
    '{12'd32,   12'd32,   12'd9,    12'd9,    16'd200, 1'b0},
    '{12'd4095, 12'd4095, 12'd2100, 12'd4095, 16'd25,  1'b1},
    '{12'd0,    12'd15,   12'd0,    12'd8,    16'd20,  1'b0},
    '{12'd16,   12'd16,   12'd18,   12'd18,   16'd120, 1'b1},
    '{12'd33,   12'd47,   12'd18,   12'd26,   16'd80,  1'b0},
    '{12'd16,   12'd19,   12'd9,    12'd11,   16'd150, 1'b1}
  };

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data  = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  logic        typed_now  = 1'b0;
  logic        typed_has  = 1'b0;
  out_item_t   typed_res  = '0;
  bit          steady_tail = 1'b0;
  bit          send_busy = 1'b0;
  int unsigned send_mode_left = 0;

  int unsigned frame_w, frame_h, cell_w, cell_h;
  int unsigned zone_sum [ZONE_COLS];
  int unsigned pix_col, pix_row, col_in_cell, zone_col, row_in_cell, zone_row;
  out_item_t   cell_q [$];

  int unsigned errors = 0;
  int unsigned pixels_taken = 0;
  int unsigned cells_checked = 0;
  int unsigned last_cells = 0;
  int unsigned reg_writes = 0;
  int unsigned cycles = 0;

  grid_zone_luma_average u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic int unsigned clamp_dim(input int unsigned v);
    return (v > DIM_LIMIT) ? DIM_LIMIT : v;
  endfunction

  function automatic void size_cells();
    cell_w = clamp_dim(frame_w) / ZONE_COLS;
    cell_h = clamp_dim(frame_h) / ZONE_ROWS;
  endfunction

  function automatic void restart_frame();
    foreach (zone_sum[i]) zone_sum[i] = 0;
    pix_col     = 0;
    pix_row     = 0;
    col_in_cell = 0;
    zone_col    = 0;
    row_in_cell = 0;
    zone_row    = 0;
  endfunction

  function automatic void take_pixel(input in_item_t px, output bit emit,
                                     output out_item_t res);
    bit sizes_ok, in_cols, in_rows;
    int unsigned gc;
    emit = 1'b0;
    res = '0;
    sizes_ok = (cell_w != 0) && (cell_h != 0);
    if (px.frame_start) restart_frame();
    in_cols = zone_col < ZONE_COLS;
    in_rows = zone_row < ZONE_ROWS;
    if (sizes_ok && in_cols && in_rows) begin
      gc = zone_col;
      zone_sum[gc] = (zone_sum[gc] + px.luma) & SUM_MASK;
      if (col_in_cell + 1 >= cell_w && row_in_cell + 1 >= cell_h) begin
        res.cell_x    = gc[3:0];
        res.cell_y    = zone_row[3:0];
        res.average   = 8'(zone_sum[gc] / (cell_w * cell_h));
        res.last_cell = (gc == ZONE_COLS - 1) && (zone_row == ZONE_ROWS - 1);
        zone_sum[gc]  = 0;
        emit = 1'b1;
      end
    end
    if (sizes_ok && in_cols) begin
      col_in_cell++;
      if (col_in_cell >= cell_w) begin
        col_in_cell = 0;
        zone_col++;
      end
    end
    pix_col++;
    if (pix_col >= clamp_dim(frame_w)) begin
      pix_col     = 0;
      col_in_cell = 0;
      zone_col    = 0;
      if (sizes_ok && in_rows) begin
        row_in_cell++;
        if (row_in_cell >= cell_h) begin
          row_in_cell = 0;
          zone_row++;
        end
      end
      pix_row++;
      if (pix_row >= clamp_dim(frame_h)) restart_frame();
    end
    pix_col     &= 32'h7FF;
    pix_row     &= 32'h7FF;
    col_in_cell &= 32'hFF;
    row_in_cell &= 32'hFF;
  endfunction

  function automatic int unsigned sender_gap();
    if (steady_tail) return 0;
    if (send_mode_left == 0) begin
      send_busy      = $urandom_range(0, 2) != 0;
      send_mode_left = $urandom_range(20, 80);
    end
    send_mode_left--;
    if (send_busy && $urandom_range(0, 3) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic write_reg(input logic reg_idx, input logic [11:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {20'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_FRAME_WIDTH) frame_w = value;
    else frame_h = value;
    size_cells();
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain_cells();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cell_q.size() != 0) @(negedge clk);
    repeat (CELL_LATENCY) @(negedge clk);
  endtask

  task automatic offer_pixel(input in_item_t px, input logic typed, input logic has,
                             input out_item_t res, input int unsigned gap);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= px;
    typed_now  <= typed;
    typed_has  <= has;
    typed_res  <= res;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin : cell_checker
    bit emit;
    out_item_t res, want;
    cycles++;
    if (rst_n && in_valid && !in_stall) begin
      take_pixel(in_data, emit, res);
      pixels_taken++;
      if (typed_now) begin
        emit = typed_has;
        res  = typed_res;
      end
      if (emit) cell_q.push_back(res);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (cell_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected cell: x=%0d y=%0d avg=%0d last=%0d", out_data.cell_x,
                   out_data.cell_y, out_data.average, out_data.last_cell);
      end else begin
        want = cell_q.pop_front();
        cells_checked++;
        if (out_data.last_cell) last_cells++;
        if (out_data.cell_x !== want.cell_x || out_data.cell_y !== want.cell_y ||
            out_data.average !== want.average || out_data.last_cell !== want.last_cell) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("cell mismatch: exp x=%0d y=%0d avg=%0d last=%0d,",
                     want.cell_x, want.cell_y, want.average, want.last_cell,
                     " got x=%0d y=%0d avg=%0d last=%0d",
                     out_data.cell_x, out_data.cell_y, out_data.average, out_data.last_cell);
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d cells still awaited", cycles, cell_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : out_pacing
    int unsigned hold_left, burst_left, mode_left;
    bit busy, held;
    hold_left  = 0;
    burst_left = 0;
    mode_left  = 0;
    busy       = 1'b0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && cells_checked >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        busy      = $urandom_range(0, 2) != 0;
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left != 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (!steady_tail && busy && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    step_row_t   row;
    phase_t      ph;
    in_item_t    px;
    int unsigned since_start, frame_len;
    logic [11:0] w, h;
    frame_w = FW_RESET;
    frame_h = FH_RESET;
    size_cells();
    restart_frame();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      if (row.kind == ROW_PIXEL) begin
        px.luma        = row.value[7:0];
        px.frame_start = row.fs;
        offer_pixel(px, row.typed, row.has_cell, row.exp_res, sender_gap());
      end else begin
        drain_cells();
        write_reg(row.kind == ROW_WIDTH ? REG_FRAME_WIDTH : REG_FRAME_HEIGHT, row.value);
      end
    end

    foreach (frame_phases[p]) begin
      ph = frame_phases[p];
      w  = 12'($urandom_range(ph.w_hi, ph.w_lo));
      h  = 12'($urandom_range(ph.h_hi, ph.h_lo));
      drain_cells();
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      frame_len   = clamp_dim(w) * clamp_dim(h);
      since_start = 0;
      if (p == N_PHASES - 1) steady_tail = 1'b1;
      for (int k = 0; k < ph.items; k++) begin
        if (p == PAUSE_PHASE && k == PAUSE_AT) drain_cells();
        if ($urandom_range(0, 7) == 0) px.luma = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else px.luma = 8'($urandom);
        px.frame_start = 1'b0;
        // restart at the natural frame boundary about half the time
        if (frame_len != 0 && since_start == frame_len) begin
          since_start    = 0;
          px.frame_start = 1'($urandom_range(0, 1));
        end
        if (k == 0 && ph.fresh) px.frame_start = 1'b1;
        else if ($urandom_range(0, 299) == 0) px.frame_start = 1'b1;
        since_start = px.frame_start ? 1 : since_start + 1;
        offer_pixel(px, 1'b0, 1'b0, NO_CELL, sender_gap());
      end
    end

    drain_cells();
    $display("Fed %0d pixels across %0d register writes, from empty grids to oversized frames;",
             pixels_taken, reg_writes);
    $display("checked %0d cell averages, %0d of them marked as the final cell.",
             cells_checked, last_cells);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
